FILE: design/knn_pkg.sv
// Shared types and constants for the nearest-neighbor vote classifier.
// Used by every module of the design; depends on nothing else.
package knn_pkg;

    localparam int FEAT_W      = 16;
    localparam int DIST_W      = 34;
    localparam int LABEL_W     = 2;
    localparam int OUT_W       = 2;
    localparam int FIELD_COUNT = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic signed [FEAT_W-1:0] feat_t;
    typedef logic [DIST_W-1:0]        dist_t;
    typedef logic [LABEL_W-1:0]       label_t;

    // Largest squared distance that four Q8.8 differences can produce.
    localparam dist_t DIST_MAX = 34'd17179344900;
    // Reset value of an empty list slot.
    localparam dist_t DIST_FAR = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_X0,
        CFG_QUERY_X1,
        CFG_QUERY_X2,
        CFG_QUERY_X3
    } cfg_idx_t;

    // One beat handed from the distance pipeline to the sorted list.
    typedef struct packed {
        logic   load;
        logic   last;
        logic   keep;
        label_t label;
        dist_t  dist_sq;
    } ins_t;

endpackage

FILE: design/knn_sq_lane.sv
// One feature lane: difference to the query and its registered square.
// Depends on knn_pkg.
module knn_sq_lane (
    input  logic          clk,
    input  logic          en,
    input  knn_pkg::feat_t feature,
    input  knn_pkg::feat_t query,
    output knn_pkg::dist_t square
);
    import knn_pkg::*;

    logic signed [FEAT_W:0]   diff;
    logic signed [DIST_W-1:0] prod;
    dist_t                    sq_reg;

    always_comb
    begin
        diff = {feature[FEAT_W-1], feature} - {query[FEAT_W-1], query};
        prod = DIST_W'(diff) * DIST_W'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= dist_t'($unsigned(prod));
        end
    end

    assign square = sq_reg;

endmodule

FILE: design/knn_list.sv
// Sorted list of the nearest points with parallel insertion.
// Depends on knn_pkg; presents the post-insert list to the vote stage.
module knn_list #(
    parameter int NEIGHBOURS = 3
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  knn_pkg::ins_t                             ins,
    output logic [NEIGHBOURS-1:0][knn_pkg::LABEL_W-1:0] view_label,
    output logic [NEIGHBOURS-1:0]                     view_valid,
    output knn_pkg::dist_t                            view_dist0
);
    import knn_pkg::*;

    dist_t                 dist_reg  [NEIGHBOURS];
    label_t                label_reg [NEIGHBOURS];
    logic [NEIGHBOURS-1:0] valid_reg;

    dist_t                 dist_next  [NEIGHBOURS];
    label_t                label_next [NEIGHBOURS];
    logic [NEIGHBOURS-1:0] valid_next;
    logic [NEIGHBOURS-1:0] take;

    // A slot takes the new point or the one shifted from above it when the
    // new distance is strictly smaller, so an equal distance keeps the older
    // point ahead. Empty slots take any point that is kept.
    always_comb
    begin
        for (int i = 0; i < NEIGHBOURS; i++)
        begin
            take[i] = ins.keep && (!valid_reg[i] || (ins.dist_sq < dist_reg[i]));
        end
        for (int i = 0; i < NEIGHBOURS; i++)
        begin
            dist_next[i]  = dist_reg[i];
            label_next[i] = label_reg[i];
            valid_next[i] = valid_reg[i];
            if (take[i])
            begin
                if (i == 0)
                begin
                    dist_next[i]  = ins.dist_sq;
                    label_next[i] = ins.label;
                    valid_next[i] = 1'b1;
                end
                else if (!take[i-1])
                begin
                    dist_next[i]  = ins.dist_sq;
                    label_next[i] = ins.label;
                    valid_next[i] = 1'b1;
                end
                else
                begin
                    dist_next[i]  = dist_reg[i-1];
                    label_next[i] = label_reg[i-1];
                    valid_next[i] = valid_reg[i-1];
                end
            end
        end
        for (int i = 0; i < NEIGHBOURS; i++)
        begin
            view_label[i] = label_next[i];
        end
        view_valid = valid_next;
        view_dist0 = valid_next[0] ? dist_next[0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < NEIGHBOURS; i++)
            begin
                dist_reg[i]  <= DIST_FAR;
                label_reg[i] <= '0;
            end
        end
        else if (ins.load)
        begin
            if (ins.last)
            begin
                valid_reg <= '0;
                for (int i = 0; i < NEIGHBOURS; i++)
                begin
                    dist_reg[i]  <= DIST_FAR;
                    label_reg[i] <= '0;
                end
            end
            else
            begin
                valid_reg <= valid_next;
                for (int i = 0; i < NEIGHBOURS; i++)
                begin
                    dist_reg[i]  <= dist_next[i];
                    label_reg[i] <= label_next[i];
                end
            end
        end
    end

endmodule

FILE: design/knn_vote.sv
// Vote stage: snapshot of the final list, label count and majority pick,
// and the output register. Depends on knn_pkg.
module knn_vote #(
    parameter int NEIGHBOURS  = 3,
    parameter int NUM_CLASSES = 3
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      snap_load,
    input  logic [NEIGHBOURS-1:0][knn_pkg::LABEL_W-1:0] view_label,
    input  logic [NEIGHBOURS-1:0]                     view_valid,
    input  knn_pkg::dist_t                            view_dist0,
    input  logic                                      out_ready,
    output logic                                      out_valid,
    output logic [knn_pkg::OUT_W-1:0]                 vote_class,
    output logic [knn_pkg::OUT_W-1:0]                 winning_votes,
    output knn_pkg::dist_t                            nearest_distance,
    output logic [knn_pkg::OUT_W-1:0]                 neighbours_used,
    output logic                                      snap_busy
);
    import knn_pkg::*;

    localparam int CNT_W = $clog2(NEIGHBOURS + 1);
    localparam int CLS_W = $clog2(NUM_CLASSES);

    logic                                  snap_valid_reg;
    logic [NEIGHBOURS-1:0][LABEL_W-1:0]    snap_label_reg;
    logic [NEIGHBOURS-1:0]                 snap_used_reg;
    dist_t                                 snap_dist_reg;

    logic                                  out_valid_reg;
    logic [OUT_W-1:0]                      class_reg;
    logic [OUT_W-1:0]                      votes_reg;
    dist_t                                 dist_reg;
    logic [OUT_W-1:0]                      used_reg;

    logic                                  snap_move;
    logic [CNT_W-1:0]                      counts [NUM_CLASSES];
    logic [CLS_W-1:0]                      win;
    logic [CNT_W-1:0]                      win_votes;
    logic [CNT_W-1:0]                      used_cnt;

    assign snap_move = snap_valid_reg && (!out_valid_reg || out_ready);
    assign snap_busy = snap_valid_reg && !snap_move;

    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            counts[c] = '0;
            for (int i = 0; i < NEIGHBOURS; i++)
            begin
                if (snap_used_reg[i] && (int'(snap_label_reg[i]) == c))
                begin
                    counts[c] = counts[c] + CNT_W'(1);
                end
            end
        end
        // Strictly greater replaces, so a tie stays with the lower class.
        win       = '0;
        win_votes = counts[0];
        for (int c = 1; c < NUM_CLASSES; c++)
        begin
            if (counts[c] > win_votes)
            begin
                win       = CLS_W'(c);
                win_votes = counts[c];
            end
        end
        used_cnt = CNT_W'($countones(snap_used_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_load || (snap_valid_reg && !snap_move);
            out_valid_reg  <= snap_move || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_label_reg <= view_label;
            snap_used_reg  <= view_valid;
            snap_dist_reg  <= view_dist0;
        end
        if (snap_move)
        begin
            class_reg <= OUT_W'(win);
            votes_reg <= OUT_W'(win_votes);
            dist_reg  <= snap_dist_reg;
            used_reg  <= OUT_W'(used_cnt);
        end
    end

    assign out_valid        = out_valid_reg;
    assign vote_class       = class_reg;
    assign winning_votes    = votes_reg;
    assign nearest_distance = dist_reg;
    assign neighbours_used  = used_reg;

endmodule

FILE: design/knn_nearest_vote_classifier_core.sv
// Top level of the streaming nearest-neighbor vote classifier.
// Depends on knn_pkg, knn_sq_lane, knn_list and knn_vote.

// The block takes one training point per beat and sustains one beat per
// cycle while input ready is high. A point passes the feature lanes (one
// difference and one 17 by 17 bit square per feature, side by side, each
// square registered), the merging adder that sums the lane squares into a
// registered 34-bit distance, and the sorted list, where every slot
// compares the new distance in parallel and the whole list shifts at once.
// A point whose class label is not a valid class leaves the list untouched.
// The beat marked last snapshots the list after its own insertion, clears
// the list, and the vote result then moves into the output register when
// that register is empty or being read. The vote counts only filled slots;
// a tie goes to the lowest class, and an empty list gives all-zero fields.
// A result waiting in the output register does not stop training points;
// input ready drops only when a second last point reaches the list while a
// previous result is still waiting on both the vote snapshot and the output
// register. Query registers are to be written by the user through the plain
// write port only while the block is idle; the block does not enforce this.
module knn_nearest_vote_classifier_core #(
    parameter int NEIGHBOURS   = 3,
    parameter int NUM_FEATURES = 4,
    parameter int NUM_CLASSES  = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [knn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  knn_pkg::feat_t                     feature_a,
    input  knn_pkg::feat_t                     feature_b,
    input  knn_pkg::feat_t                     feature_c,
    input  knn_pkg::feat_t                     feature_d,
    input  knn_pkg::label_t                    class_label,
    input  logic                               is_last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [knn_pkg::OUT_W-1:0]          vote_class,
    output logic [knn_pkg::OUT_W-1:0]          winning_votes,
    output knn_pkg::dist_t                     nearest_distance,
    output logic [knn_pkg::OUT_W-1:0]          neighbours_used
);
    import knn_pkg::*;

    // Only four feature fields exist, so at most four lanes are built.
    localparam int USED_F = (NUM_FEATURES < FIELD_COUNT) ? NUM_FEATURES : FIELD_COUNT;

    feat_t  query_reg [FIELD_COUNT];
    feat_t  feat      [FIELD_COUNT];
    dist_t  square    [USED_F];

    logic   st1_valid_reg;
    logic   st1_last_reg;
    label_t st1_label_reg;

    logic   st2_valid_reg;
    logic   st2_last_reg;
    label_t st2_label_reg;
    dist_t  st2_dist_reg;

    dist_t  dist_sum;
    logic   in_accept;
    logic   adv1;
    logic   adv2;
    logic   stall_ins;
    logic   snap_busy;
    ins_t   ins;

    logic [NEIGHBOURS-1:0][LABEL_W-1:0] view_label;
    logic [NEIGHBOURS-1:0]              view_valid;
    dist_t                              view_dist0;

    // Query registers. Every index selects one of the four query registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FIELD_COUNT; i++)
            begin
                query_reg[i] <= '0;
            end
        end
        else if (cfg_wen)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_QUERY_X0: query_reg[0] <= feat_t'(cfg_wdata);
                CFG_QUERY_X1: query_reg[1] <= feat_t'(cfg_wdata);
                CFG_QUERY_X2: query_reg[2] <= feat_t'(cfg_wdata);
                CFG_QUERY_X3: query_reg[3] <= feat_t'(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign feat[0] = feature_a;
    assign feat[1] = feature_b;
    assign feat[2] = feature_c;
    assign feat[3] = feature_d;

    // Pipeline flow: the only stall source is a last point that cannot
    // hand its snapshot to the vote stage.
    assign stall_ins = st2_last_reg && snap_busy;
    assign adv2      = !st2_valid_reg || !stall_ins;
    assign adv1      = !st1_valid_reg || adv2;
    assign in_ready  = adv1;
    assign in_accept = in_valid && in_ready;

    // Feature lanes.
    for (genvar g = 0; g < USED_F; g++)
    begin : g_lane
        knn_sq_lane u_lane (
            .clk     (clk),
            .en      (in_accept),
            .feature (feat[g]),
            .query   (query_reg[g]),
            .square  (square[g])
        );
    end

    // Merging stage: sum of the lane squares.
    always_comb
    begin
        dist_sum = '0;
        for (int i = 0; i < USED_F; i++)
        begin
            dist_sum = dist_sum + square[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                st1_valid_reg <= in_accept;
            end
            if (adv2)
            begin
                st2_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            st1_last_reg  <= is_last;
            st1_label_reg <= class_label;
        end
        if (st1_valid_reg && adv2)
        begin
            st2_last_reg  <= st1_last_reg;
            st2_label_reg <= st1_label_reg;
            st2_dist_reg  <= dist_sum;
        end
    end

    always_comb
    begin
        ins.load    = st2_valid_reg && !stall_ins;
        ins.last    = st2_last_reg;
        ins.keep    = int'(st2_label_reg) < NUM_CLASSES;
        ins.label   = st2_label_reg;
        ins.dist_sq = st2_dist_reg;
    end

    knn_list #(
        .NEIGHBOURS (NEIGHBOURS)
    ) u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .ins        (ins),
        .view_label (view_label),
        .view_valid (view_valid),
        .view_dist0 (view_dist0)
    );

    knn_vote #(
        .NEIGHBOURS  (NEIGHBOURS),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_vote (
        .clk              (clk),
        .rst_n            (rst_n),
        .snap_load        (ins.load && ins.last),
        .view_label       (view_label),
        .view_valid       (view_valid),
        .view_dist0       (view_dist0),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .vote_class       (vote_class),
        .winning_votes    (winning_votes),
        .nearest_distance (nearest_distance),
        .neighbours_used  (neighbours_used),
        .snap_busy        (snap_busy)
    );

    // The winner is always a real class.
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(vote_class) < NUM_CLASSES))
        else $error("vote class out of range");

    // No squared distance can exceed the largest four-square sum.
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (nearest_distance <= DIST_MAX))
        else $error("nearest distance out of range");

    // An empty list votes nothing, picks class zero and reports no distance.
    a_empty_vote: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (NEIGHBOURS < 4) && (neighbours_used == '0))
        |-> ((winning_votes == '0) && (nearest_distance == '0)
             && (vote_class == '0)))
        else $error("empty list produced a vote");

    // The winner cannot hold more votes than there were voters.
    a_votes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (NEIGHBOURS < 4)) |-> (winning_votes <= neighbours_used))
        else $error("winning votes exceed voters");

endmodule
